/* rtl/svu_pkg.sv */
// shared widths, latencies and pipeline sideband types for the seek steering unit
package svu_pkg;

   localparam int WORD_W      = 32;
   localparam int SPEED_W     = 31;
   localparam int DIFF_W      = WORD_W + 1;
   localparam int MAG_W       = WORD_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int RAD_W       = SQ_W + 1;
   localparam int ROOT_W      = (RAD_W + 1) / 2;
   localparam int NUM_W       = MAG_W + SPEED_W;
   localparam int QUO_W       = SPEED_W;
   localparam int LIM_W       = 2 * SPEED_W;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = QUO_W;
   localparam int LINE_LEN    = SQRT_STAGES + DIV_STAGES;

   typedef struct packed {
      logic [NUM_W-1:0]         num_x;
      logic [NUM_W-1:0]         num_y;
      logic                     neg_x;
      logic                     neg_y;
      logic                     nz;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
   } side1_type;

   typedef struct packed {
      logic [WORD_W-1:0] s_x;
      logic [WORD_W-1:0] s_y;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic              neg_x;
      logic              neg_y;
      logic              exceed;
   } side2_type;

endpackage

/* rtl/svu_sqrt.sv */
// pipelined floor square root, one result bit per stage
module svu_sqrt (
   input  logic                        clock,
   input  logic [svu_pkg::RAD_W-1:0]   rad,
   output logic [svu_pkg::ROOT_W-1:0]  root
);
   import svu_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [RAD_W:0]    rad_ff  [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [RAD_W:0]    rad_p;
      logic [REM_W-1:0]  rem_s;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W:0]    rad_in;

      if (g == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = {1'b0, rad};
      end else begin : g_next
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
         assign rad_p  = rad_ff[g-1];
      end

      assign rem_s   = {rem_p[REM_W-3:0], rad_p[RAD_W:RAD_W-1]};
      assign trial   = {1'b0, root_p, 2'b01};
      assign ge      = rem_s >= trial;
      assign rem_in  = ge ? rem_s - trial : rem_s;
      assign root_in = {root_p[ROOT_W-2:0], ge};
      assign rad_in  = {rad_p[RAD_W-2:0], 2'b00};

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         rad_ff[g]  <= rad_in;
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

/* rtl/svu_div.sv */
// pipelined restoring divider, one quotient bit per stage
module svu_div (
   input  logic                        clock,
   input  logic [svu_pkg::NUM_W-1:0]   num,
   input  logic [svu_pkg::ROOT_W-1:0]  den,
   output logic [svu_pkg::QUO_W-1:0]   quo
);
   import svu_pkg::*;

   logic [ROOT_W-1:0] rem_ff [DIV_STAGES];
   logic [QUO_W-1:0]  low_ff [DIV_STAGES];
   logic [ROOT_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [ROOT_W-1:0] rem_p;
      logic [QUO_W-1:0]  low_p;
      logic [ROOT_W-1:0] den_p;
      logic [QUO_W-1:0]  quo_p;
      logic [ROOT_W:0]   rem_s;
      logic              ge;
      logic [ROOT_W:0]   diff;
      logic [ROOT_W-1:0] rem_in;
      logic [QUO_W-1:0]  low_in;
      logic [QUO_W-1:0]  quo_in;

      if (g == 0) begin : g_first
         assign rem_p = ROOT_W'(num[NUM_W-1:QUO_W]);
         assign low_p = num[QUO_W-1:0];
         assign den_p = den;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[g-1];
         assign low_p = low_ff[g-1];
         assign den_p = den_ff[g-1];
         assign quo_p = quo_ff[g-1];
      end

      assign rem_s  = {rem_p, low_p[QUO_W-1]};
      assign ge     = rem_s >= {1'b0, den_p};
      assign diff   = rem_s - {1'b0, den_p};
      assign rem_in = ge ? diff[ROOT_W-1:0] : rem_s[ROOT_W-1:0];
      assign low_in = {low_p[QUO_W-2:0], 1'b0};
      assign quo_in = {quo_p[QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         low_ff[g] <= low_in;
         den_ff[g] <= den_p;
         quo_ff[g] <= quo_in;
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

/* rtl/seek_steering_vector_unit.sv */
// top level of the seek steering unit: input stages, two limit passes and the result register
//
// Fully pipelined: one transaction is taken every clock cycle and busy stays low. Each result
// appears on rsp_steer_x and rsp_steer_y with rsp_strobe once its start has passed through two
// passes of a 33-stage square root followed by a 31-stage divider, plus the subtract, magnitude,
// multiply, sum and sign stages and the result register. Results come in start order and must be
// taken in the cycle they are shown. max_speed is written through the csr port, which is always
// ready; write it only while no transaction is in flight.
module seek_steering_vector_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_target_x,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_target_y,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_pos_x,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_pos_y,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_vel_x,
   input  logic signed [svu_pkg::WORD_W-1:0]  req_vel_y,
   output logic                               rsp_strobe,
   output logic signed [svu_pkg::WORD_W-1:0]  rsp_steer_x,
   output logic signed [svu_pkg::WORD_W-1:0]  rsp_steer_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [svu_pkg::SPEED_W-1:0]        csr_max_speed
);
   import svu_pkg::*;

   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(262144);
   localparam int LATENCY = 2 * LINE_LEN + 10;

   logic [SPEED_W-1:0] speed_ff;

   // input stage: differences
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] dx0_ff, dy0_ff;
   logic signed [WORD_W-1:0] vx0_ff, vy0_ff;
   logic                     accept;

   // magnitudes
   logic                     v1_ff;
   logic [MAG_W-1:0]         ax1_ff, ay1_ff;
   logic                     negx1_ff, negy1_ff, nz1_ff;
   logic signed [WORD_W-1:0] vx1_ff, vy1_ff;
   logic [DIFF_W-1:0]        ax1_in, ay1_in;

   // products
   logic                     v2_ff;
   logic [SQ_W-1:0]          sqx2_ff, sqy2_ff;
   logic [NUM_W-1:0]         nx2_ff, ny2_ff;
   logic                     negx2_ff, negy2_ff, nz2_ff;
   logic signed [WORD_W-1:0] vx2_ff, vy2_ff;

   // sum of squares
   logic                     v3_ff;
   logic [RAD_W-1:0]         sum3_ff;
   side1_type                side3_ff;

   logic                     vld1_ff [LINE_LEN];
   side1_type                line1_ff [LINE_LEN];
   logic [ROOT_W-1:0]        root1;
   logic [QUO_W-1:0]         qx1, qy1;

   // desired velocity and difference
   logic                     va_ff;
   logic signed [WORD_W-1:0] wxa_ff, wya_ff, vxa_ff, vya_ff;
   logic [WORD_W-1:0]        wxa_in, wya_in;
   side1_type                tap1;

   logic                     vb_ff;
   logic signed [DIFF_W-1:0] sxb_ff, syb_ff;

   logic                     vc_ff;
   logic [MAG_W-1:0]         axc_ff, ayc_ff;
   logic                     negxc_ff, negyc_ff;
   logic [WORD_W-1:0]        sxc_ff, syc_ff;
   logic [DIFF_W-1:0]        axc_in, ayc_in;

   logic                     vd_ff;
   logic [SQ_W-1:0]          sqxd_ff, sqyd_ff;
   logic [NUM_W-1:0]         nxd_ff, nyd_ff;
   logic [LIM_W-1:0]         limd_ff;
   logic                     negxd_ff, negyd_ff;
   logic [WORD_W-1:0]        sxd_ff, syd_ff;

   logic                     ve_ff;
   logic [RAD_W-1:0]         sume_ff;
   logic [LIM_W-1:0]         lime_ff;
   logic [NUM_W-1:0]         nxe_ff, nye_ff;
   logic                     negxe_ff, negye_ff;
   logic [WORD_W-1:0]        sxe_ff, sye_ff;
   side2_type                side2_in;

   logic                     vld2_ff [LINE_LEN];
   side2_type                line2_ff [LINE_LEN];
   logic [ROOT_W-1:0]        root2;
   logic [QUO_W-1:0]         qx2, qy2;
   side2_type                tap2;

   logic                     strobe_ff;
   logic [WORD_W-1:0]        steer_x_ff, steer_y_ff;
   logic [WORD_W-1:0]        steer_x_in, steer_y_in;
   logic [WORD_W-1:0]        qsx, qsy;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
      end else if (csr_valid && csr_ready) begin
         speed_ff <= csr_max_speed;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         strobe_ff <= 1'b0;
         for (int k = 0; k < LINE_LEN; k++) begin
            vld1_ff[k] <= 1'b0;
            vld2_ff[k] <= 1'b0;
         end
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vld1_ff[0] <= v3_ff;
         for (int k = 1; k < LINE_LEN; k++) begin
            vld1_ff[k] <= vld1_ff[k-1];
            vld2_ff[k] <= vld2_ff[k-1];
         end
         va_ff <= vld1_ff[LINE_LEN-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vld2_ff[0] <= ve_ff;
         strobe_ff <= vld2_ff[LINE_LEN-1];
      end
   end

   // first pass: direction scaled to max speed
   assign ax1_in = dx0_ff[DIFF_W-1] ? -dx0_ff : dx0_ff;
   assign ay1_in = dy0_ff[DIFF_W-1] ? -dy0_ff : dy0_ff;

   always_ff @(posedge clock) begin
      dx0_ff <= DIFF_W'(req_target_x) - DIFF_W'(req_pos_x);
      dy0_ff <= DIFF_W'(req_target_y) - DIFF_W'(req_pos_y);
      vx0_ff <= req_vel_x;
      vy0_ff <= req_vel_y;

      ax1_ff   <= ax1_in[MAG_W-1:0];
      ay1_ff   <= ay1_in[MAG_W-1:0];
      negx1_ff <= dx0_ff[DIFF_W-1];
      negy1_ff <= dy0_ff[DIFF_W-1];
      nz1_ff   <= (dx0_ff != '0) || (dy0_ff != '0);
      vx1_ff   <= vx0_ff;
      vy1_ff   <= vy0_ff;

      sqx2_ff  <= ax1_ff * ax1_ff;
      sqy2_ff  <= ay1_ff * ay1_ff;
      nx2_ff   <= ax1_ff * speed_ff;
      ny2_ff   <= ay1_ff * speed_ff;
      negx2_ff <= negx1_ff;
      negy2_ff <= negy1_ff;
      nz2_ff   <= nz1_ff;
      vx2_ff   <= vx1_ff;
      vy2_ff   <= vy1_ff;

      sum3_ff        <= {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      side3_ff.num_x <= nx2_ff;
      side3_ff.num_y <= ny2_ff;
      side3_ff.neg_x <= negx2_ff;
      side3_ff.neg_y <= negy2_ff;
      side3_ff.nz    <= nz2_ff;
      side3_ff.vel_x <= vx2_ff;
      side3_ff.vel_y <= vy2_ff;

      line1_ff[0] <= side3_ff;
      for (int k = 1; k < LINE_LEN; k++) begin
         line1_ff[k] <= line1_ff[k-1];
      end
   end

   svu_sqrt u_sqrt1 (.clock(clock), .rad(sum3_ff), .root(root1));

   svu_div u_div1x (
      .clock(clock), .num(line1_ff[SQRT_STAGES-1].num_x), .den(root1), .quo(qx1)
   );
   svu_div u_div1y (
      .clock(clock), .num(line1_ff[SQRT_STAGES-1].num_y), .den(root1), .quo(qy1)
   );

   // second pass: difference against velocity and limit
   assign tap1   = line1_ff[LINE_LEN-1];
   assign wxa_in = !tap1.nz ? '0 : tap1.neg_x ? -WORD_W'(qx1) : WORD_W'(qx1);
   assign wya_in = !tap1.nz ? '0 : tap1.neg_y ? -WORD_W'(qy1) : WORD_W'(qy1);
   assign axc_in = sxb_ff[DIFF_W-1] ? -sxb_ff : sxb_ff;
   assign ayc_in = syb_ff[DIFF_W-1] ? -syb_ff : syb_ff;

   always_comb begin
      side2_in.s_x    = sxe_ff;
      side2_in.s_y    = sye_ff;
      side2_in.num_x  = nxe_ff;
      side2_in.num_y  = nye_ff;
      side2_in.neg_x  = negxe_ff;
      side2_in.neg_y  = negye_ff;
      side2_in.exceed = sume_ff > RAD_W'(lime_ff);
   end

   always_ff @(posedge clock) begin
      wxa_ff <= wxa_in;
      wya_ff <= wya_in;
      vxa_ff <= tap1.vel_x;
      vya_ff <= tap1.vel_y;

      sxb_ff <= DIFF_W'(wxa_ff) - DIFF_W'(vxa_ff);
      syb_ff <= DIFF_W'(wya_ff) - DIFF_W'(vya_ff);

      axc_ff   <= axc_in[MAG_W-1:0];
      ayc_ff   <= ayc_in[MAG_W-1:0];
      negxc_ff <= sxb_ff[DIFF_W-1];
      negyc_ff <= syb_ff[DIFF_W-1];
      sxc_ff   <= sxb_ff[WORD_W-1:0];
      syc_ff   <= syb_ff[WORD_W-1:0];

      sqxd_ff  <= axc_ff * axc_ff;
      sqyd_ff  <= ayc_ff * ayc_ff;
      nxd_ff   <= axc_ff * speed_ff;
      nyd_ff   <= ayc_ff * speed_ff;
      limd_ff  <= speed_ff * speed_ff;
      negxd_ff <= negxc_ff;
      negyd_ff <= negyc_ff;
      sxd_ff   <= sxc_ff;
      syd_ff   <= syc_ff;

      sume_ff  <= {1'b0, sqxd_ff} + {1'b0, sqyd_ff};
      lime_ff  <= limd_ff;
      nxe_ff   <= nxd_ff;
      nye_ff   <= nyd_ff;
      negxe_ff <= negxd_ff;
      negye_ff <= negyd_ff;
      sxe_ff   <= sxd_ff;
      sye_ff   <= syd_ff;

      line2_ff[0] <= side2_in;
      for (int k = 1; k < LINE_LEN; k++) begin
         line2_ff[k] <= line2_ff[k-1];
      end
   end

   svu_sqrt u_sqrt2 (.clock(clock), .rad(sume_ff), .root(root2));

   svu_div u_div2x (
      .clock(clock), .num(line2_ff[SQRT_STAGES-1].num_x), .den(root2), .quo(qx2)
   );
   svu_div u_div2y (
      .clock(clock), .num(line2_ff[SQRT_STAGES-1].num_y), .den(root2), .quo(qy2)
   );

   // result register
   assign tap2       = line2_ff[LINE_LEN-1];
   assign qsx        = tap2.neg_x ? -WORD_W'(qx2) : WORD_W'(qx2);
   assign qsy        = tap2.neg_y ? -WORD_W'(qy2) : WORD_W'(qy2);
   assign steer_x_in = tap2.exceed ? qsx : tap2.s_x;
   assign steer_y_in = tap2.exceed ? qsy : tap2.s_y;

   always_ff @(posedge clock) begin
      steer_x_ff <= steer_x_in;
      steer_y_ff <= steer_y_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_steer_x = steer_x_ff;
   assign rsp_steer_y = steer_y_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result strobe not at fixed latency");

   a_dir_root : assert property (@(posedge clock) disable iff (reset)
      vld1_ff[SQRT_STAGES-1] && line1_ff[SQRT_STAGES-1].nz |-> root1 != '0)
      else $error("nonzero direction with zero length");

   a_lim_root : assert property (@(posedge clock) disable iff (reset)
      vld2_ff[SQRT_STAGES-1] && line2_ff[SQRT_STAGES-1].exceed |-> root2 != '0)
      else $error("limit taken with zero length");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the seek steering unit: directed and random transactions
module testbench;
   import svu_pkg::*;

   localparam int LATENCY = 2 * LINE_LEN + 10;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 31'd262144;
   localparam logic [SPEED_W-1:0] SPEED_TOP = {SPEED_W{1'b1}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

   typedef struct {
      logic signed [WORD_W-1:0] steer_x;
      logic signed [WORD_W-1:0] steer_y;
   } steer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [WORD_W-1:0] req_target_x = '0, req_target_y = '0;
   logic signed [WORD_W-1:0] req_pos_x = '0, req_pos_y = '0;
   logic signed [WORD_W-1:0] req_vel_x = '0, req_vel_y = '0;
   logic rsp_strobe;
   logic signed [WORD_W-1:0] rsp_steer_x, rsp_steer_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SPEED_W-1:0] csr_max_speed = '0;

   logic [SPEED_W-1:0] speed_model = SPEED_RESET;
   steer_type steer_queue[$];
   int errors = 0;

   seek_steering_vector_unit u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [127:0] mag_sq(input longint a, input longint b);
      logic [127:0] ua, ub;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return ua * ua + ub * ub;
   endfunction

   function automatic longint floor_sqrt(input logic [127:0] v);
      logic [67:0] rem, root, trial;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | v[2*i +: 2];
         trial = (root << 2) | 68'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 68'd1;
         end else begin
            root = root << 1;
         end
      end
      return longint'(root);
   endfunction

   function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
      if (v > longint'(WORD_MAX)) return WORD_MAX;
      if (v < longint'(WORD_MIN)) return WORD_MIN;
      return v[WORD_W-1:0];
   endfunction

   function automatic steer_type predict_steer(input logic [SPEED_W-1:0] spd);
      longint m, dx, dy, wx, wy, sx, sy, len;
      logic [127:0] lim;
      steer_type r;
      m = longint'(spd);
      dx = longint'(req_target_x) - longint'(req_pos_x);
      dy = longint'(req_target_y) - longint'(req_pos_y);
      wx = 0;
      wy = 0;
      if (dx != 0 || dy != 0) begin
         len = floor_sqrt(mag_sq(dx, dy));
         wx = (dx * m) / len;
         wy = (dy * m) / len;
      end
      sx = wx - longint'(req_vel_x);
      sy = wy - longint'(req_vel_y);
      lim = 128'(m) * 128'(m);
      if (mag_sq(sx, sy) > lim) begin
         len = floor_sqrt(mag_sq(sx, sy));
         sx = (sx * m) / len;
         sy = (sy * m) / len;
      end
      r.steer_x = clamp_word(sx);
      r.steer_y = clamp_word(sy);
      return r;
   endfunction

   // accept transactions, track the register, check results
   always @(posedge clock) begin
      steer_type e;
      if (!reset) begin
         if (start && !busy) begin
            steer_queue.push_back(predict_steer(speed_model));
         end
         if (csr_valid && csr_ready) speed_model = csr_max_speed;
         if (rsp_strobe) begin
            if (steer_queue.size() == 0) begin
               $error("unexpected result x=%0d y=%0d", rsp_steer_x, rsp_steer_y);
               errors++;
            end else begin
               e = steer_queue.pop_front();
               if (rsp_steer_x !== e.steer_x) begin
                  $error("steer_x expected %0d actual %0d", e.steer_x, rsp_steer_x);
                  errors++;
               end
               if (rsp_steer_y !== e.steer_y) begin
                  $error("steer_y expected %0d actual %0d", e.steer_y, rsp_steer_y);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_item(input logic signed [WORD_W-1:0] tx, ty, px, py, vx, vy);
      @(negedge clock);
      req_target_x <= tx;
      req_target_y <= ty;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      pause_sender(0);
      while (steer_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_speed(input logic [SPEED_W-1:0] v);
      @(negedge clock);
      csr_max_speed <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return WORD_MAX - $urandom_range(0, 3);
         1: return WORD_MIN + $urandom_range(0, 3);
         2: return $urandom_range(0, 1023) - 512;
         3: return $urandom_range(0, 32'h0010_0000) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(0, 0, 0, 0, 0, 0);
      send_item(100, -100, 100, -100, 5, 7);
      send_item(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 0, 0);
      send_item(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
      send_item(WORD_MAX, 0, WORD_MIN, 0, WORD_MIN, WORD_MIN);
      send_item(0, WORD_MIN, 0, WORD_MAX, WORD_MAX, WORD_MAX);
      send_item(32'sh0001_0000, 0, 0, 0, 0, 0);
      send_item(32'sh0001_0000, 0, 0, 0, 32'sh0004_0000, 0);
      send_item(1, 1, 0, 0, 1, -1);
      send_item(-1, 0, 0, 0, -1, -1);
      send_item(0, 0, 0, 0, WORD_MAX, WORD_MIN);
      send_item(-32'sd1, -32'sd1, 0, 0, -32'sd1, -32'sd1);
      drain();
      write_speed(0);
      send_item(500, 300, 0, 0, 1000, -7);
      send_item(0, 0, 0, 0, 0, 0);
      send_item(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
      drain();
      write_speed(SPEED_TOP);
      send_item(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_item(WORD_MIN, 0, WORD_MAX, 0, WORD_MAX, 0);
      send_item(0, 0, 0, 0, WORD_MIN, WORD_MIN);
      send_item(3, 4, 0, 0, 0, 0);
      send_item(0, 0, 0, 0, -1, -1);
      drain();
      write_speed(1);
      send_item(7, -9, 0, 0, 0, 0);
      send_item(0, 0, 0, 0, 1, 0);
      drain();
   endtask

   // bursts with random gaps, most targets near the agent
   task automatic test_random(input logic [SPEED_W-1:0] spd, input int count);
      int left, burst;
      logic signed [WORD_W-1:0] px, py;
      write_speed(spd);
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            px = rand_word();
            py = rand_word();
            if ($urandom_range(0, 3) != 0)
               send_item(px + ($urandom_range(0, 2047) - 1024),
                         py + ($urandom_range(0, 2047) - 1024),
                         px, py, rand_word(), rand_word());
            else
               send_item(rand_word(), rand_word(), px, py, rand_word(), rand_word());
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 12));
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(SPEED_RESET, 250);
      test_random(SPEED_TOP, 250);
      test_random(0, 150);
      test_random(31'($urandom_range(1, 255)), 250);
      test_random(31'($urandom), 325);
      if (errors == 0)
         $display("[seek_steering_vector_unit] OK");
      else
         $display("[seek_steering_vector_unit] ERROR");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("[seek_steering_vector_unit] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/svu_pkg.sv
rtl/svu_sqrt.sv
rtl/svu_div.sv
rtl/seek_steering_vector_unit.sv
tb/testbench.sv
